// ----- sv/wli_pkg.sv -----
// ----------------------------------------------------------------------------
// wli_pkg: shared types and constants for the waypoint interpolator
// Axis widths, the waypoint vector type and the segment descriptor that the
// front end hands to the point sequencer through the queue.
// ----------------------------------------------------------------------------
package wli_pkg;

  localparam int AXES    = 4;
  localparam int AXIS_W  = 24;
  // Sample index width covers segments of up to 64 points.
  localparam int IDX_W   = 6;
  // Quotient of a magnitude below 2^24 by the segment divisor.
  localparam int QUO_W   = 24;
  // Twice a remainder of a divisor of at most 63.
  localparam int REM2_W  = 7;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [AXES-1:0][AXIS_W-1:0] point_t;

  // One segment: start point, per-axis direction, and the per-sample step of
  // the rounded quotient split into whole part and doubled remainder.
  typedef struct packed {
    point_t                          prev;
    logic [AXES-1:0]                 neg;
    logic [AXES-1:0][QUO_W-1:0]      quo;
    logic [AXES-1:0][REM2_W-1:0]     rem2;
  } seg_entry_t;

endpackage

// ----- sv/waypoint_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator: evenly spaced points between waypoints
// Usage notes for the four-axis waypoint interpolator.
// ----------------------------------------------------------------------------
// Input channel (in_*): one waypoint per transfer, four signed Q15.8 axes.
// The first waypoint after reset is only stored. Each later waypoint makes a
// segment of SAMPLES_PER_SEGMENT points from the previous waypoint to this
// one, both ends included, each axis rounded to nearest, halves away from 0.
// Output channel (out_*): one point per transfer with its sample index and a
// flag on the segment's final point.
// The first point of a segment passes three setup stages, the queue, the
// sequencer's segment register and the output register after the waypoint
// transfer. The sequencer emits one point per cycle while the receiver is
// ready, SAMPLES_PER_SEGMENT points per waypoint; the front end keeps
// accepting waypoints until its two-entry queue and pipeline fill.
// A stalled receiver freezes the output register and the sequencer; the
// front end stalls only when the queue is full.
// Reset (rst_n low, synchronous) empties pipeline and queue and forgets the
// stored waypoint.
// ----------------------------------------------------------------------------
module waypoint_linear_interpolator #(
  parameter int SAMPLES_PER_SEGMENT = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wli_pkg::axis_t            in_way_x,
  input  wli_pkg::axis_t            in_way_y,
  input  wli_pkg::axis_t            in_way_z,
  input  wli_pkg::axis_t            in_way_grip,
  output logic                      out_valid,
  input  logic                      out_ready,
  output wli_pkg::axis_t            out_pt_x,
  output wli_pkg::axis_t            out_pt_y,
  output wli_pkg::axis_t            out_pt_z,
  output wli_pkg::axis_t            out_pt_grip,
  output logic [wli_pkg::IDX_W-1:0] out_sample_index,
  output logic                      out_segment_last
);
  import wli_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_SEGMENT - 1);

  point_t      in_point, out_point;
  logic        q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  seg_entry_t  q_push_entry, q_pop_entry;

  // Axis ports to vector and back.
  assign in_point    = {in_way_grip, in_way_z, in_way_y, in_way_x};
  assign out_pt_x    = out_point[0];
  assign out_pt_y    = out_point[1];
  assign out_pt_z    = out_point[2];
  assign out_pt_grip = out_point[3];

  wli_front #(
    .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point   (in_point),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry)
  );

  wli_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_entry  (q_pop_entry)
  );

  wli_back #(
    .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (q_pop_valid),
    .pop_ready        (q_pop_ready),
    .pop_entry        (q_pop_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point        (out_point),
    .out_sample_index (out_sample_index),
    .out_segment_last (out_segment_last)
  );

  // The last-point flag marks exactly the final sample index.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_segment_last == (out_sample_index == LAST_IDX)))
    else $error("segment_last does not match the final sample index");

  // Within a segment the next point follows in the very next cycle.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_segment_last) |=> out_valid)
    else $error("gap inside a segment");

  // Within a segment the sample index steps by one.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_segment_last) |=>
      (out_sample_index == IDX_W'($past(out_sample_index) + 1'b1)))
    else $error("sample index did not advance by one");

  // A new segment starts at index zero.
  a_segment_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_segment_last) |=>
      (!out_valid || (out_sample_index == '0)))
    else $error("segment did not start at index zero");

endmodule

// ----- sv/wli_front.sv -----
// ----------------------------------------------------------------------------
// wli_front: waypoint intake and segment setup
// Keeps the previous waypoint, makes no segment from the first one after reset, and turns each
// later waypoint into a segment descriptor over a three-stage pipeline.
// ----------------------------------------------------------------------------
module wli_front #(
  parameter int SAMPLES_PER_SEGMENT = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wli_pkg::point_t     in_point,
  output logic                push_valid,
  input  logic                push_ready,
  output wli_pkg::seg_entry_t push_entry
);
  import wli_pkg::*;

  localparam int DEN         = SAMPLES_PER_SEGMENT - 1;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = AXIS_W + RECIP_W;
  localparam int QD_W        = QUO_W + IDX_W;
  // Rounded-up reciprocal; exact floor quotient for all magnitudes below 2^24.
  localparam longint unsigned RECIP_L =
    ((longint'(1) << RECIP_SHIFT) + longint'(DEN) - 1) / longint'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [IDX_W-1:0]   DEN_V = IDX_W'(DEN);

  logic                          have_prev_r;
  point_t                        prev_r;

  logic                          s1_valid_r;
  point_t                        s1_prev_r;
  logic [AXES-1:0]               s1_neg_r;
  logic [AXES-1:0][AXIS_W-1:0]   s1_mag_r;

  logic                          s2_valid_r;
  point_t                        s2_prev_r;
  logic [AXES-1:0]               s2_neg_r;
  logic [AXES-1:0][AXIS_W-1:0]   s2_mag_r;
  logic [AXES-1:0][PROD_W-1:0]   s2_prod_r;

  logic                          s3_valid_r;
  seg_entry_t                    s3_entry_r;

  logic                          s1_adv, s2_adv, s3_adv, accept;
  logic [AXES-1:0]               s1_neg_nxt;
  logic [AXES-1:0][AXIS_W-1:0]   s1_mag_nxt;
  logic [AXES-1:0][PROD_W-1:0]   s2_prod_nxt;
  seg_entry_t                    s3_entry_nxt;

  // Each stage moves on when the stage after it is empty or moving.
  assign s3_adv   = !s3_valid_r || push_ready;
  assign s2_adv   = !s2_valid_r || s3_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;
  assign accept   = in_valid && in_ready;

  assign push_valid = s3_valid_r;
  assign push_entry = s3_entry_r;

  // Difference to the previous waypoint as sign and magnitude.
  always_comb begin
    logic signed [AXIS_W:0] diff;
    for (int a = 0; a < AXES; a++) begin
      diff = {in_point[a][AXIS_W-1], in_point[a]} - {prev_r[a][AXIS_W-1], prev_r[a]};
      s1_neg_nxt[a] = diff[AXIS_W];
      s1_mag_nxt[a] = diff[AXIS_W] ? AXIS_W'(-diff) : diff[AXIS_W-1:0];
    end
  end

  // Reciprocal product for the magnitude divided by the segment divisor.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      s2_prod_nxt[a] = {{RECIP_W{1'b0}}, s1_mag_r[a]} * {{AXIS_W{1'b0}}, RECIP};
    end
  end

  // Quotient and remainder; the doubled remainder feeds the rounding.
  always_comb begin
    logic [QUO_W-1:0] q;
    logic [QD_W-1:0]  qd;
    logic [IDX_W-1:0] rem;
    s3_entry_nxt.prev = s2_prev_r;
    s3_entry_nxt.neg  = s2_neg_r;
    for (int a = 0; a < AXES; a++) begin
      q   = s2_prod_r[a][RECIP_SHIFT +: QUO_W];
      qd  = {{IDX_W{1'b0}}, q} * {{QUO_W{1'b0}}, DEN_V};
      rem = s2_mag_r[a][IDX_W-1:0] - qd[IDX_W-1:0];
      s3_entry_nxt.quo[a]  = q;
      s3_entry_nxt.rem2[a] = {rem, 1'b0};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        have_prev_r <= 1'b1;
        prev_r      <= in_point;
      end
      if (s1_adv) s1_valid_r <= accept && have_prev_r;
      if (s2_adv) s2_valid_r <= s1_valid_r;
      if (s3_adv) s3_valid_r <= s2_valid_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_prev_r <= prev_r;
      s1_neg_r  <= s1_neg_nxt;
      s1_mag_r  <= s1_mag_nxt;
    end
    if (s2_adv) begin
      s2_prev_r <= s1_prev_r;
      s2_neg_r  <= s1_neg_r;
      s2_mag_r  <= s1_mag_r;
      s2_prod_r <= s2_prod_nxt;
    end
    if (s3_adv) begin
      s3_entry_r <= s3_entry_nxt;
    end
  end

endmodule

// ----- sv/wli_queue.sv -----
// ----------------------------------------------------------------------------
// wli_queue: two-entry segment queue
// Decouples segment setup from point generation so each side stalls alone.
// ----------------------------------------------------------------------------
module wli_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  wli_pkg::seg_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output wli_pkg::seg_entry_t pop_entry
);
  import wli_pkg::*;

  seg_entry_t  mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ----- sv/wli_back.sv -----
// ----------------------------------------------------------------------------
// wli_back: point sequencer
// Steps through the samples of one segment, one point per cycle while not stalled,
// keeping the rounded quotient as a running sum, and drives the registered result.
// ----------------------------------------------------------------------------
module wli_back #(
  parameter int SAMPLES_PER_SEGMENT = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  wli_pkg::seg_entry_t           pop_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wli_pkg::point_t               out_point,
  output logic [wli_pkg::IDX_W-1:0]     out_sample_index,
  output logic                          out_segment_last
);
  import wli_pkg::*;

  localparam int ACC_R_W = REM2_W + 1;
  localparam int DEN     = SAMPLES_PER_SEGMENT - 1;
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(DEN);
  localparam logic [ACC_R_W-1:0] DEN2       = ACC_R_W'(2 * DEN);
  localparam logic [ACC_R_W-1:0] ACC_R_INIT = ACC_R_W'(DEN);

  logic                          active_r;
  seg_entry_t                    seg_r;
  logic [IDX_W-1:0]              j_r;
  logic [AXES-1:0][QUO_W-1:0]    acc_q_r;
  logic [AXES-1:0][ACC_R_W-1:0]  acc_r_r;
  logic                          out_valid_r;
  point_t                        out_point_r;
  logic [IDX_W-1:0]              out_idx_r;
  logic                          out_last_r;

  logic                          fire, last, load;
  point_t                        point_nxt;
  logic [AXES-1:0][QUO_W-1:0]    acc_q_nxt;
  logic [AXES-1:0][ACC_R_W-1:0]  acc_r_nxt;

  assign fire      = active_r && (!out_valid_r || out_ready);
  assign last      = (j_r == LAST_IDX);
  assign pop_ready = !active_r || (fire && last);
  assign load      = pop_valid && pop_ready;

  assign out_valid        = out_valid_r;
  assign out_point        = out_point_r;
  assign out_sample_index = out_idx_r;
  assign out_segment_last = out_last_r;

  // Current point: start plus the signed rounded offset.
  always_comb begin
    logic signed [AXIS_W:0] ofs;
    logic signed [AXIS_W:0] sum;
    for (int a = 0; a < AXES; a++) begin
      ofs = seg_r.neg[a] ? -$signed({1'b0, acc_q_r[a]}) : $signed({1'b0, acc_q_r[a]});
      sum = $signed({seg_r.prev[a][AXIS_W-1], seg_r.prev[a]}) + ofs;
      point_nxt[a] = sum[AXIS_W-1:0];
    end
  end

  // Advance the running quotient by one sample, carrying from the remainder.
  always_comb begin
    logic [ACC_R_W-1:0] r_sum;
    for (int a = 0; a < AXES; a++) begin
      r_sum = acc_r_r[a] + {1'b0, seg_r.rem2[a]};
      if (r_sum >= DEN2) begin
        acc_r_nxt[a] = r_sum - DEN2;
        acc_q_nxt[a] = acc_q_r[a] + seg_r.quo[a] + QUO_W'(1);
      end else begin
        acc_r_nxt[a] = r_sum;
        acc_q_nxt[a] = acc_q_r[a] + seg_r.quo[a];
      end
    end
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load)                  active_r <= 1'b1;
      else if (fire && last)     active_r <= 1'b0;
      if (fire)                  out_valid_r <= 1'b1;
      else if (out_ready)        out_valid_r <= 1'b0;
    end
  end

  // Segment payload and accumulators.
  always_ff @(posedge clk) begin
    if (load) begin
      seg_r <= pop_entry;
      j_r   <= '0;
      for (int a = 0; a < AXES; a++) begin
        acc_q_r[a] <= '0;
        acc_r_r[a] <= ACC_R_INIT;
      end
    end else if (fire) begin
      j_r     <= j_r + IDX_W'(1);
      acc_q_r <= acc_q_nxt;
      acc_r_r <= acc_r_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_point_r <= point_nxt;
      out_idx_r   <= j_r;
      out_last_r  <= last;
    end
  end

endmodule
